### rtl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg: constants for the seconds-to-calendar converter
// Holds the year span, the reciprocals used for the constant divisions, the
// month-start tables and the span length in days.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int NUM_YEARS     = 64;
  localparam int BASE_YEAR     = 1970;
  localparam int LEAP_CYCLE    = 4;
  localparam int EPOCH_WEEKDAY = 4;

  // 86400 = 128 * 675; the low seven bits of the seconds pass straight through.
  localparam int DAY_SHIFT  = 7;
  localparam int DAY_ODD    = 675;
  localparam int CYCLE_DAYS = 1461;
  localparam int YEAR_DAYS  = 365;
  localparam int WEEK_DAYS  = 7;
  localparam int HOUR_SECS  = 3600;
  localparam int MIN_SECS   = 60;

  // Years are counted in four-year cycles that start on 1 January 1969.
  localparam int CYCLE_BASE_YEAR = 1969;

  localparam int DAY_RECIP_BITS = 35;
  localparam int RECIP_BITS     = 17;

  localparam logic [25:0] RECIP_DAY   = 26'((64'd1 << DAY_RECIP_BITS) / 64'(DAY_ODD));
  localparam logic [6:0]  RECIP_CYCLE = 7'((64'd1 << RECIP_BITS) / 64'(CYCLE_DAYS));
  localparam logic [14:0] RECIP_WEEK  = 15'((64'd1 << RECIP_BITS) / 64'(WEEK_DAYS));
  localparam logic [5:0]  RECIP_HOUR  = 6'((64'd1 << RECIP_BITS) / 64'(HOUR_SECS));
  localparam logic [11:0] RECIP_MIN   = 12'((64'd1 << RECIP_BITS) / 64'(MIN_SECS));

  localparam logic [8:0] PLAIN_START [13] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  localparam logic [8:0] LEAP_START [13] = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
    9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
  };

  function automatic int span_days(int n);
    int total;
    total = 0;
    for (int y = 0; y < n; y++) begin
      total = total + ((((BASE_YEAR + y) % LEAP_CYCLE) == 0) ? 366 : 365);
    end
    return total;
  endfunction

  localparam logic [15:0] SPAN_DAYS = 16'(span_days(NUM_YEARS));

endpackage

### rtl/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: seconds since 1970 to calendar fields
// Splits a 32-bit epoch time into time of day, weekday and calendar date.
// ----------------------------------------------------------------------------
// The input channel takes one word per accepted cycle: seconds since
// 1970-01-01 00:00:00. The output channel gives one word per input word:
// second, minute, hour, weekday, year, day_of_year, month, day_of_month and
// out_of_range. A word is moved when valid is high and stall is low.
// The block is a seven-stage pipeline that accepts one word in every cycle
// in which it is not stalled. The stages hold the two constant-divisor
// multiply-and-correct steps and the year and month decode.
// When the receiver stalls a valid result, the whole pipeline holds and the
// input channel is stalled in the same cycle; nothing is dropped.
// Years are leap years every fourth year from 1972. A day beyond the year
// span sets out_of_range and zeroes year, day_of_year, month and
// day_of_month; the time-of-day fields and weekday are still given.
// Reset empties the pipeline; there is no other state.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  second,
  output logic [5:0]  minute,
  output logic [4:0]  hour,
  output logic [2:0]  weekday,
  output logic [10:0] year,
  output logic [8:0]  day_of_year,
  output logic [3:0]  month,
  output logic [4:0]  day_of_month,
  output logic        out_of_range
);

  logic advance;
  logic v1, v2, v3, v4, v5, v6;

  // Stage 1: input register.
  logic [31:0] s1_secs;

  // Stage 2: approximate day count.
  logic [50:0] s2_prod;
  logic [15:0] s2_q;
  logic [24:0] s2_x;
  logic [6:0]  s2_low;

  // Stage 3: corrected day count and second of day.
  logic [25:0] s3_diff;
  logic [10:0] s3_rest;
  logic [15:0] s3_days_next;
  logic [16:0] s3_rem_next;
  logic [15:0] s3_days;
  logic [16:0] s3_rem;

  // Stage 4: approximate quotients.
  logic [16:0] s4_dp_c, s4_wx_c;
  logic [23:0] s4_cyc_prod;
  logic [31:0] s4_wk_prod;
  logic [22:0] s4_hr_prod;
  logic [28:0] s4_mt_prod;
  logic [5:0]  s4_cyc;
  logic [16:0] s4_dp, s4_wx, s4_rem;
  logic [14:0] s4_wq;
  logic [4:0]  s4_hr;
  logic [10:0] s4_mt;
  logic [15:0] s4_days;

  // Stage 5: corrected quotients and remainders.
  logic [16:0] s5_cyc_diff, s5_wk_diff, s5_hr_diff, s5_mt_diff;
  logic [5:0]  s5_cyc;
  logic [10:0] s5_within;
  logic [2:0]  s5_wday;
  logic [4:0]  s5_hour;
  logic [10:0] s5_mt;
  logic [5:0]  s5_sec;
  logic        s5_oor;

  // Stage 6: year, day of year and minute.
  logic [1:0]  s6_yic_c;
  logic [10:0] s6_doy_w;
  logic [10:0] s6_min_w;
  logic [11:0] s6_year;
  logic [8:0]  s6_doy;
  logic        s6_leap;
  logic [5:0]  s6_min;
  logic [2:0]  s6_wday;
  logic [4:0]  s6_hour;
  logic [5:0]  s6_sec;
  logic        s6_oor;

  // Stage 7: month decode.
  logic [3:0]  s7_mon;
  logic [8:0]  s7_start;
  logic [8:0]  s7_mday_w;

  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      out_valid <= v6;
    end
  end

  assign s2_prod = 51'(s1_secs[31:DAY_SHIFT]) * 51'(RECIP_DAY);

  always_comb begin
    s3_diff = 26'(s2_x) - 26'(s2_q) * 26'(DAY_ODD);
    s3_rest = s3_diff[10:0];
    if (s3_rest >= 11'(DAY_ODD)) begin
      s3_days_next = s2_q + 16'd1;
      s3_rem_next  = {s3_rest[9:0] - 10'(DAY_ODD), s2_low};
    end else begin
      s3_days_next = s2_q;
      s3_rem_next  = {s3_rest[9:0], s2_low};
    end
  end

  assign s4_dp_c     = 17'(s3_days) + 17'(YEAR_DAYS);
  assign s4_wx_c     = 17'(s3_days) + 17'(EPOCH_WEEKDAY);
  assign s4_cyc_prod = 24'(s4_dp_c) * 24'(RECIP_CYCLE);
  assign s4_wk_prod  = 32'(s4_wx_c) * 32'(RECIP_WEEK);
  assign s4_hr_prod  = 23'(s3_rem) * 23'(RECIP_HOUR);
  assign s4_mt_prod  = 29'(s3_rem) * 29'(RECIP_MIN);

  assign s5_cyc_diff = s4_dp - 17'(s4_cyc) * 17'(CYCLE_DAYS);
  assign s5_wk_diff  = s4_wx - 17'(s4_wq) * 17'(WEEK_DAYS);
  assign s5_hr_diff  = s4_rem - 17'(s4_hr) * 17'(HOUR_SECS);
  assign s5_mt_diff  = s4_rem - 17'(s4_mt) * 17'(MIN_SECS);

  always_comb begin
    if (s5_within < 11'(YEAR_DAYS)) begin
      s6_yic_c = 2'd0;
      s6_doy_w = s5_within;
    end else if (s5_within < 11'(2 * YEAR_DAYS)) begin
      s6_yic_c = 2'd1;
      s6_doy_w = s5_within - 11'(YEAR_DAYS);
    end else if (s5_within < 11'(3 * YEAR_DAYS)) begin
      s6_yic_c = 2'd2;
      s6_doy_w = s5_within - 11'(2 * YEAR_DAYS);
    end else begin
      s6_yic_c = 2'd3;
      s6_doy_w = s5_within - 11'(3 * YEAR_DAYS);
    end
  end

  assign s6_min_w = s5_mt - 11'(s5_hour) * 11'(MIN_SECS);

  always_comb begin
    s7_mon = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if ((s6_leap ? LEAP_START[i] : PLAIN_START[i]) <= s6_doy) begin
        s7_mon = 4'(i);
      end
    end
    s7_start  = s6_leap ? LEAP_START[s7_mon] : PLAIN_START[s7_mon];
  end

  assign s7_mday_w = s6_doy - s7_start + 9'd1;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_secs <= seconds;

      s2_q   <= s2_prod[DAY_RECIP_BITS +: 16];
      s2_x   <= s1_secs[31:DAY_SHIFT];
      s2_low <= s1_secs[DAY_SHIFT-1:0];

      s3_days <= s3_days_next;
      s3_rem  <= s3_rem_next;

      s4_cyc  <= s4_cyc_prod[RECIP_BITS +: 6];
      s4_wq   <= s4_wk_prod[RECIP_BITS +: 15];
      s4_hr   <= s4_hr_prod[RECIP_BITS +: 5];
      s4_mt   <= s4_mt_prod[RECIP_BITS +: 11];
      s4_dp   <= s4_dp_c;
      s4_wx   <= s4_wx_c;
      s4_rem  <= s3_rem;
      s4_days <= s3_days;

      if (s5_cyc_diff >= 17'(CYCLE_DAYS)) begin
        s5_cyc    <= s4_cyc + 6'd1;
        s5_within <= 11'(s5_cyc_diff - 17'(CYCLE_DAYS));
      end else begin
        s5_cyc    <= s4_cyc;
        s5_within <= 11'(s5_cyc_diff);
      end
      if (s5_wk_diff >= 17'(WEEK_DAYS)) begin
        s5_wday <= 3'(s5_wk_diff - 17'(WEEK_DAYS));
      end else begin
        s5_wday <= 3'(s5_wk_diff);
      end
      if (s5_hr_diff >= 17'(HOUR_SECS)) begin
        s5_hour <= s4_hr + 5'd1;
      end else begin
        s5_hour <= s4_hr;
      end
      if (s5_mt_diff >= 17'(MIN_SECS)) begin
        s5_mt  <= s4_mt + 11'd1;
        s5_sec <= 6'(s5_mt_diff - 17'(MIN_SECS));
      end else begin
        s5_mt  <= s4_mt;
        s5_sec <= 6'(s5_mt_diff);
      end
      s5_oor <= (s4_days >= SPAN_DAYS);

      s6_year <= 12'(CYCLE_BASE_YEAR) + 12'({s5_cyc, 2'b00}) + 12'(s6_yic_c);
      s6_doy  <= s6_doy_w[8:0];
      s6_leap <= (s6_yic_c == 2'd3);
      s6_min  <= s6_min_w[5:0];
      s6_wday <= s5_wday;
      s6_hour <= s5_hour;
      s6_sec  <= s5_sec;
      s6_oor  <= s5_oor;

      second       <= s6_sec;
      minute       <= s6_min;
      hour         <= s6_hour;
      weekday      <= s6_wday;
      out_of_range <= s6_oor;
      year         <= s6_oor ? 11'd0 : s6_year[10:0];
      day_of_year  <= s6_oor ? 9'd0 : s6_doy;
      month        <= s6_oor ? 4'd0 : s7_mon;
      day_of_month <= s6_oor ? 5'd0 : s7_mday_w[4:0];
    end
  end

endmodule
